### rtl/etm_pkg.sv
// Shared types and constants for the Euler transform matrix block.
// Used by euler_transform_matrix and etm_div; depends on nothing else.
`default_nettype none
package etm_pkg;

  // Angle units: 1/256 degree
  localparam logic signed [18:0] TURN_UNITS   = 19'sd92160;
  localparam logic signed [18:0] HALF_TURN    = 19'sd46080;
  localparam logic signed [18:0] QUARTER_TURN = 19'sd23040;

  // pi/46080 in Q30 split as integer part plus remainder over 46080
  localparam logic [31:0] ZPI_INT   = 32'd73204;
  localparam logic [28:0] ZPI_FRAC  = 29'd19106;
  localparam logic [28:0] ZPI_HALF  = 29'd23040;
  // ceil(2^25 / 45), exact for the 19-bit operand range used here
  localparam logic [38:0] RECIP_45  = 39'd745655;

  localparam logic signed [31:0] GAIN_Q30  = 32'sd652032874;
  localparam logic signed [31:0] ENTRY_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] ENTRY_MIN = 32'sh80000000;

  localparam int NUM_COLS = 7;
  localparam logic [2:0] ITEM_GAP = 3'(NUM_COLS - 1);

  localparam logic KIND_MODEL  = 1'b0;
  localparam logic KIND_NORMAL = 1'b1;

  typedef struct packed {
    logic neg;   // quotient sign
    logic zero;  // divisor is zero
    logic tpos;  // term > 0
    logic tneg;  // term < 0
  } etm_div_ctl_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### rtl/etm_div.sv
// Pipelined rounding divider for one normal-matrix entry, one quotient bit
// per stage, then sign, saturation and zero-divisor handling. Uses etm_pkg.
`default_nettype none
module etm_div
  import etm_pkg::*;
#(
  parameter int NUM_W = 36,
  parameter int DEN_W = 24
) (
  input  wire               clk,
  input  wire  [NUM_W-1:0]  num,
  input  wire  [DEN_W-1:0]  den,
  input  wire etm_div_ctl_t ctl,
  output logic signed [31:0] quo
);

  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0] qd_r  [NUM_W];
  logic [DEN_W-1:0] den_r [NUM_W];
  etm_div_ctl_t     ctl_r [NUM_W];
  logic signed [31:0] quo_r;

  genvar k;
  generate
    for (k = 0; k < NUM_W; k++) begin : g_step
      logic [DEN_W-1:0] rem_p;
      logic [NUM_W-1:0] qd_p;
      logic [DEN_W-1:0] den_p;
      etm_div_ctl_t     ctl_p;
      logic [DEN_W:0]   sh_w, diff_w;
      logic             ge_w;
      logic [DEN_W-1:0] rem_nxt;
      logic [NUM_W-1:0] qd_nxt;

      if (k == 0) begin : g_first
        assign rem_p = '0;
        assign qd_p  = num;
        assign den_p = den;
        assign ctl_p = ctl;
      end else begin : g_rest
        assign rem_p = rem_r[k-1];
        assign qd_p  = qd_r[k-1];
        assign den_p = den_r[k-1];
        assign ctl_p = ctl_r[k-1];
      end

      always_comb begin
        sh_w    = {rem_p, qd_p[NUM_W-1]};
        diff_w  = sh_w - {1'b0, den_p};
        ge_w    = (sh_w >= {1'b0, den_p});
        rem_nxt = ge_w ? diff_w[DEN_W-1:0] : sh_w[DEN_W-1:0];
        qd_nxt  = {qd_p[NUM_W-2:0], ge_w};
      end

      always_ff @(posedge clk) begin
        rem_r[k] <= rem_nxt;
        qd_r[k]  <= qd_nxt;
        den_r[k] <= den_p;
        ctl_r[k] <= ctl_p;
      end
    end
  endgenerate

  logic [NUM_W-1:0]   q_w;
  logic               pos_ovf, neg_ovf;
  logic signed [31:0] quo_nxt;
  etm_div_ctl_t       cf;

  always_comb begin
    q_w     = qd_r[NUM_W-1];
    cf      = ctl_r[NUM_W-1];
    pos_ovf = |q_w[NUM_W-1:31];
    neg_ovf = (|q_w[NUM_W-1:32]) | (q_w[31] & (|q_w[30:0]));
    priority if (cf.zero) begin
      priority if (cf.tpos) quo_nxt = ENTRY_MAX;
      else if (cf.tneg)     quo_nxt = ENTRY_MIN;
      else                  quo_nxt = '0;
    end else if (cf.neg) begin
      quo_nxt = neg_ovf ? ENTRY_MIN : -$signed(q_w[31:0]);
    end else begin
      quo_nxt = pos_ovf ? ENTRY_MAX : $signed(q_w[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
  end

  assign quo = quo_r;

endmodule
`default_nettype wire

### rtl/euler_transform_matrix.sv
// Euler transform to model and normal matrix columns: top level with angle
// reduction, CORDIC, product terms and output sequencer. Uses etm_pkg, etm_div.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  input    | start / busy       | in_angle_{x,y,z}, in_scale_{x,y,z}, in_move_{x,y,z}
//  result   | out_strobe         | out_matrix_kind, out_column_index, out_entry_{x,y,z},
//           |                    | out_zero_scale, out_last_column
//
// A transform gives seven column words on consecutive cycles; busy holds
// after each accept until the single result port can take the next seven, and a
// new transform can be accepted while earlier ones are still in the pipe. The
// divider has NUM_W = 36 stages at the defaults, one per quotient bit. Reset is
// synchronous and clears valid bits, sequencer and busy. The receiver cannot
// stall, so nothing in the pipe waits.
`default_nettype none
module euler_transform_matrix
  import etm_pkg::*;
#(
  parameter int CORDIC_STEPS = 18,
  parameter int FRAC_BITS    = 16
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire  signed [17:0] in_angle_x,
  input  wire  signed [17:0] in_angle_y,
  input  wire  signed [17:0] in_angle_z,
  input  wire  signed [23:0] in_scale_x,
  input  wire  signed [23:0] in_scale_y,
  input  wire  signed [23:0] in_scale_z,
  input  wire  signed [31:0] in_move_x,
  input  wire  signed [31:0] in_move_y,
  input  wire  signed [31:0] in_move_z,
  output logic               out_strobe,
  output logic               out_matrix_kind,
  output logic [1:0]         out_column_index,
  output logic signed [31:0] out_entry_x,
  output logic signed [31:0] out_entry_y,
  output logic signed [31:0] out_entry_z,
  output logic               out_zero_scale,
  output logic               out_last_column
);

  localparam int N      = CORDIC_STEPS;
  localparam int EXP    = 2 * FRAC_BITS - 30;
  localparam int NSH    = (EXP > 0) ? EXP : 0;
  localparam int DSH    = (EXP < 0) ? -EXP : 0;
  localparam int TW     = 33;
  localparam int NUM_W  = TW + NSH + 1;
  localparam int DEN_W  = 24 + DSH;
  localparam int ST_S   = N + 7;
  localparam int ST_OUT = ST_S + NUM_W + 1;

  typedef struct packed {
    logic [2:0][23:0] sc;
    logic [2:0][31:0] mv;
    logic [2:0]       flip;
  } side_t;

  typedef struct packed {
    logic [2:0][2:0][31:0] me;
    logic [2:0][31:0]      mv;
    logic [2:0]            zs;
  } mdl_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  idx;
    logic [31:0] ex;
    logic [31:0] ey;
    logic [31:0] ez;
    logic        zf;
    logic        last;
  } col_t;

  function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return p[61:30];
  endfunction

  function automatic logic signed [31:0] sat_entry(input logic signed [56:0] v);
    logic signed [31:0] r;
    priority if (v > 57'sd2147483647)   r = ENTRY_MAX;
    else if (v < -57'sd2147483648)      r = ENTRY_MIN;
    else                                r = v[31:0];
    return r;
  endfunction

  // ---------------- accept and rate control
  logic       acc;
  logic [2:0] gap_r, gap_nxt;

  assign acc  = start & ~busy;
  assign busy = (gap_r != 3'd0);

  always_comb begin
    priority if (acc)         gap_nxt = ITEM_GAP;
    else if (gap_r != 3'd0)   gap_nxt = gap_r - 3'd1;
    else                      gap_nxt = gap_r;
  end

  logic [ST_OUT:1] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= '0;
      vld_r <= '0;
    end else begin
      gap_r <= gap_nxt;
      vld_r <= {vld_r[ST_OUT-1:1], acc};
    end
  end

  // ---------------- side data line
  side_t sd_r [1:ST_S-1];

  // ---------------- angle reduction (stage 1)
  logic signed [18:0] ang_w [3];
  logic signed [18:0] red_w [3];
  logic signed [18:0] fold_w [3];
  logic [2:0]         flip_w;
  logic [14:0]        mag_w [3];
  logic [14:0]        mag_r [3];
  logic [2:0]         neg1_r, neg2_r;

  always_comb begin
    ang_w[0] = 19'(in_angle_x);
    ang_w[1] = 19'(in_angle_y);
    ang_w[2] = 19'(in_angle_z);
    for (int j = 0; j < 3; j++) begin
      priority if (ang_w[j] >= HALF_TURN)  red_w[j] = ang_w[j] - TURN_UNITS;
      else if (ang_w[j] < -HALF_TURN)      red_w[j] = ang_w[j] + TURN_UNITS;
      else                                 red_w[j] = ang_w[j];
      flip_w[j] = 1'b1;
      priority if (red_w[j] > QUARTER_TURN)       fold_w[j] = HALF_TURN - red_w[j];
      else if (red_w[j] < -QUARTER_TURN)          fold_w[j] = -HALF_TURN - red_w[j];
      else begin
        fold_w[j] = red_w[j];
        flip_w[j] = 1'b0;
      end
      mag_w[j] = fold_w[j][18] ? 15'(-fold_w[j]) : fold_w[j][14:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      mag_r[j]  <= mag_w[j];
      neg1_r[j] <= fold_w[j][18];
    end
    sd_r[1].sc   <= {in_scale_z, in_scale_y, in_scale_x};
    sd_r[1].mv   <= {in_move_z, in_move_y, in_move_x};
    sd_r[1].flip <= flip_w;
    for (int k = 2; k < ST_S; k++) sd_r[k] <= sd_r[k-1];
  end

  // ---------------- angle to Q30 radians (stages 2, 3)
  logic [31:0] zhi_r [3];
  logic [28:0] zlo_r [3];

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      zhi_r[j]  <= {17'd0, mag_r[j]} * ZPI_INT;
      zlo_r[j]  <= {14'd0, mag_r[j]} * ZPI_FRAC + ZPI_HALF;
      neg2_r[j] <= neg1_r[j];
    end
  end

  logic signed [31:0] x_r [3][N+1];
  logic signed [31:0] y_r [3][N+1];
  logic signed [32:0] z_r [3][N+1];
  logic signed [32:0] z0_w [3];

  always_comb begin
    logic [38:0] qp;
    logic [31:0] zm;
    for (int j = 0; j < 3; j++) begin
      // remainder part: floor(zlo / 46080) = floor((zlo >> 10) / 45)
      qp      = {20'd0, zlo_r[j][28:10]} * RECIP_45;
      zm      = zhi_r[j] + {18'd0, qp[38:25]};
      z0_w[j] = neg2_r[j] ? -$signed({1'b0, zm}) : $signed({1'b0, zm});
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      x_r[j][0] <= GAIN_Q30;
      y_r[j][0] <= '0;
      z_r[j][0] <= z0_w[j];
    end
  end

  // ---------------- CORDIC, one micro-rotation per stage
  genvar ga, gk;
  generate
    for (ga = 0; ga < 3; ga++) begin : g_ang
      for (gk = 0; gk < N; gk++) begin : g_rot
        logic signed [31:0] dx, dy;
        logic signed [32:0] at;
        assign dx = x_r[ga][gk] >>> gk;
        assign dy = y_r[ga][gk] >>> gk;
        assign at = $signed({1'b0, atan_q30(5'(gk))});
        always_ff @(posedge clk) begin
          if (!z_r[ga][gk][32]) begin
            x_r[ga][gk+1] <= x_r[ga][gk] - dy;
            y_r[ga][gk+1] <= y_r[ga][gk] + dx;
            z_r[ga][gk+1] <= z_r[ga][gk] - at;
          end else begin
            x_r[ga][gk+1] <= x_r[ga][gk] + dy;
            y_r[ga][gk+1] <= y_r[ga][gk] - dx;
            z_r[ga][gk+1] <= z_r[ga][gk] + at;
          end
        end
      end
    end
  endgenerate

  // ---------------- rotation terms (stages P1..P3)
  logic signed [31:0] cx, sx, cy, sy, cz, sz;

  assign cx = sd_r[N+3].flip[0] ? -x_r[0][N] : x_r[0][N];
  assign cy = sd_r[N+3].flip[1] ? -x_r[1][N] : x_r[1][N];
  assign cz = sd_r[N+3].flip[2] ? -x_r[2][N] : x_r[2][N];
  assign sx = y_r[0][N];
  assign sy = y_r[1][N];
  assign sz = y_r[2][N];

  logic signed [31:0] p_cycz_r, p_sysx_r, p_cxsz_r, p_cysx_r, p_czsy_r;
  logic signed [31:0] p_cxcz_r, p_sysz_r, p_cxsy_r, p_cycx_r, p_cysz_r;
  logic signed [31:0] p_sx_r, p_sz_r;

  always_ff @(posedge clk) begin
    p_cycz_r <= mul30(cy, cz);
    p_sysx_r <= mul30(sy, sx);
    p_cxsz_r <= mul30(cx, sz);
    p_cysx_r <= mul30(cy, sx);
    p_czsy_r <= mul30(cz, sy);
    p_cxcz_r <= mul30(cx, cz);
    p_sysz_r <= mul30(sy, sz);
    p_cxsy_r <= mul30(cx, sy);
    p_cycx_r <= mul30(cy, cx);
    p_cysz_r <= mul30(cy, sz);
    p_sx_r   <= sx;
    p_sz_r   <= sz;
  end

  logic signed [31:0] q_sysxsz_r, q_cysxsz_r, q_czsysx_r, q_cyczsx_r;
  logic signed [31:0] q_cycz_r, q_cxsz_r, q_czsy_r, q_cysz_r;
  logic signed [31:0] q_cxcz_r, q_sysz_r, q_cxsy_r, q_sx_r, q_cycx_r;

  always_ff @(posedge clk) begin
    q_sysxsz_r <= mul30(p_sysx_r, p_sz_r);
    q_cysxsz_r <= mul30(p_cysx_r, p_sz_r);
    q_czsysx_r <= mul30(p_czsy_r, p_sx_r);
    q_cyczsx_r <= mul30(p_cycz_r, p_sx_r);
    q_cycz_r   <= p_cycz_r;
    q_cxsz_r   <= p_cxsz_r;
    q_czsy_r   <= p_czsy_r;
    q_cysz_r   <= p_cysz_r;
    q_cxcz_r   <= p_cxcz_r;
    q_sysz_r   <= p_sysz_r;
    q_cxsy_r   <= p_cxsy_r;
    q_sx_r     <= p_sx_r;
    q_cycx_r   <= p_cycx_r;
  end

  logic signed [TW-1:0] t_r [3][3];

  always_ff @(posedge clk) begin
    t_r[0][0] <= TW'(q_cycz_r) + TW'(q_sysxsz_r);
    t_r[0][1] <= TW'(q_cxsz_r);
    t_r[0][2] <= TW'(q_cysxsz_r) - TW'(q_czsy_r);
    t_r[1][0] <= TW'(q_czsysx_r) - TW'(q_cysz_r);
    t_r[1][1] <= TW'(q_cxcz_r);
    t_r[1][2] <= TW'(q_cyczsx_r) + TW'(q_sysz_r);
    t_r[2][0] <= TW'(q_cxsy_r);
    t_r[2][1] <= -TW'(q_sx_r);
    t_r[2][2] <= TW'(q_cycx_r);
  end

  // ---------------- scale stage: model entries and divider setup
  mdl_t               md_r [NUM_W+2];
  logic [NUM_W-1:0]   num_r [3][3];
  logic [DEN_W-1:0]   den_r [3];
  etm_div_ctl_t       ctl_r [3][3];
  logic signed [31:0] ne_w  [3][3];

  always_ff @(posedge clk) begin
    logic signed [23:0] s;
    logic signed [56:0] p;
    logic [TW-1:0]      tm;
    logic [23:0]        sm;
    logic [DEN_W-1:0]   dm;
    for (int j = 0; j < 3; j++) begin
      s  = $signed(sd_r[ST_S-1].sc[j]);
      sm = s[23] ? 24'(-s) : 24'(s);
      dm = DEN_W'(sm) << DSH;
      den_r[j]       <= dm;
      md_r[0].zs[j]  <= (s == 24'sd0);
      md_r[0].mv[j]  <= sd_r[ST_S-1].mv[j];
      for (int r = 0; r < 3; r++) begin
        p  = 57'(s) * 57'(t_r[j][r]) + 57'sd536870912;
        md_r[0].me[j][r] <= sat_entry(p >>> 30);
        tm = t_r[j][r][TW-1] ? TW'(-t_r[j][r]) : TW'(t_r[j][r]);
        num_r[j][r]      <= (NUM_W'(tm) << NSH) + NUM_W'(dm >> 1);
        ctl_r[j][r].neg  <= t_r[j][r][TW-1] ^ s[23];
        ctl_r[j][r].zero <= (s == 24'sd0);
        ctl_r[j][r].tpos <= ~t_r[j][r][TW-1] & (t_r[j][r] != '0);
        ctl_r[j][r].tneg <= t_r[j][r][TW-1];
      end
    end
    for (int k = 1; k < NUM_W + 2; k++) md_r[k] <= md_r[k-1];
  end

  genvar gj, gr;
  generate
    for (gj = 0; gj < 3; gj++) begin : g_col
      for (gr = 0; gr < 3; gr++) begin : g_row
        etm_div #(
          .NUM_W (NUM_W),
          .DEN_W (DEN_W)
        ) u_div (
          .clk (clk),
          .num (num_r[gj][gr]),
          .den (den_r[gj]),
          .ctl (ctl_r[gj][gr]),
          .quo (ne_w[gj][gr])
        );
      end
    end
  endgenerate

  // ---------------- output sequencer
  col_t       hold_r [NUM_COLS];
  logic [2:0] seq_r;
  logic       active_r;
  mdl_t       mf;

  assign mf = md_r[NUM_W+1];

  always_ff @(posedge clk) begin
    if (vld_r[ST_OUT]) begin
      for (int j = 0; j < 3; j++) begin
        hold_r[j] <= '{kind: KIND_MODEL, idx: 2'(j), ex: mf.me[j][0],
                       ey: mf.me[j][1], ez: mf.me[j][2], zf: 1'b0, last: 1'b0};
        hold_r[4+j] <= '{kind: KIND_NORMAL, idx: 2'(j), ex: ne_w[j][0],
                         ey: ne_w[j][1], ez: ne_w[j][2], zf: mf.zs[j],
                         last: (j == 2)};
      end
      hold_r[3] <= '{kind: KIND_MODEL, idx: 2'd3, ex: mf.mv[0], ey: mf.mv[1],
                     ez: mf.mv[2], zf: 1'b0, last: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      seq_r      <= '0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= active_r;
      priority if (vld_r[ST_OUT]) begin
        active_r <= 1'b1;
        seq_r    <= '0;
      end else if (active_r) begin
        // park on the last slot so the read index stays in range
        if (seq_r == ITEM_GAP) active_r <= 1'b0;
        else seq_r <= seq_r + 3'd1;
      end
    end
  end

  // word payload, read from the hold slot the sequencer points at
  always_ff @(posedge clk) begin
    out_matrix_kind  <= hold_r[seq_r].kind;
    out_column_index <= hold_r[seq_r].idx;
    out_entry_x      <= hold_r[seq_r].ex;
    out_entry_y      <= hold_r[seq_r].ey;
    out_entry_z      <= hold_r[seq_r].ez;
    out_zero_scale   <= hold_r[seq_r].zf;
    out_last_column  <= hold_r[seq_r].last;
  end

endmodule
`default_nettype wire
